>>> src/vtrp_pkg.sv
// Shared types, codes and defaults of the triplet region panner.
package vtrp_pkg;

    localparam int MAX_REGIONS_DEF  = 64;
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int COEF_BITS_DEF    = 24;
    localparam int SEARCH_CAP       = 64;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;

    localparam logic [1:0] REQ_LOAD_BASIS = 2'd0;
    localparam logic [1:0] REQ_LOAD_CHAN  = 2'd1;
    localparam logic [1:0] REQ_PAN        = 2'd2;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_TOL     = 2'd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         region_index;
        logic [3:0]         entry_index;
        logic signed [23:0] load_value;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  hit_region;
        logic [5:0]  chan_a;
        logic [5:0]  chan_b;
        logic [5:0]  chan_c;
        logic [15:0] gain_a;
        logic [15:0] gain_b;
        logic [15:0] gain_c;
    } rsp_t;

    typedef struct packed {
        logic [6:0] region_count;
        logic [7:0] sign_tolerance;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EVAL,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_CHAN,
        ST_EMIT
    } back_state_t;

endpackage

>>> src/vtrp_ram.sv
// Generic simple dual-port RAM with registered read.
module vtrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> src/vtrp_front.sv
// Front end: accepts items, drops unused request codes, queues the rest.
module vtrp_front import vtrp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic q_valid,
    output req_t q_item,
    input  logic q_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    req_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign req_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign q_valid   = (count_reg != '0);
    assign q_item    = slot_reg[rd_ptr_reg];

    // an unused request code is taken and dropped here
    assign push = req_valid && req_ready && (req.req_type != REQ_UNUSED);
    assign pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

>>> src/vtrp_back.sv
// Back end: table loads, triplet search, gain normalisation and result register.
module vtrp_back import vtrp_pkg::*; #(
    parameter int MAX_REGIONS  = MAX_REGIONS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int COEF_BITS    = COEF_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_valid,
    input  req_t q_item,
    output logic q_pop,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int PROD_W = 16 + COEF_BITS;
    localparam int RAW_W  = PROD_W + 2;
    localparam int BDEPTH = MAX_REGIONS * 9;
    localparam int CDEPTH = MAX_REGIONS * 3;
    localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int CAP    = (MAX_REGIONS < SEARCH_CAP) ? MAX_REGIONS : SEARCH_CAP;

    back_state_t state_reg, state_next;

    // memories
    logic                 b_we, b_re, c_we, c_re;
    logic [BAW-1:0]       b_waddr, b_raddr;
    logic [CAW-1:0]       c_waddr, c_raddr;
    logic [COEF_BITS-1:0] b_wdata, b_rdata;
    logic [5:0]           c_wdata, c_rdata;

    // search
    logic [6:0]  r_reg, r_next, limit;
    logic [1:0]  i_reg, i_next, j_reg, j_next;
    logic signed [15:0] pos_reg [3];
    logic signed [15:0] pos_next [3];
    logic        rd1_v_reg, rd1_v_next;
    logic [1:0]  rd1_i_reg, rd1_j_reg;
    logic        prod_v_reg;
    logic [1:0]  prod_j_reg;
    logic signed [PROD_W-1:0] prod_reg, pa, pb;
    logic signed [RAW_W-1:0]  acc_reg [3];
    logic signed [RAW_W-1:0]  acc_next [3];
    logic signed [RAW_W-1:0]  tol_s;
    logic        acc_clear;

    // normalisation
    logic [RAW_W-1:0] mag_reg [3];
    logic [RAW_W-1:0] mag_next [3];
    logic [RAW_W-1:0] mag_e [3];
    logic [RAW_W-1:0] m_reg, m_next, m_e;
    logic [2:0]  posf_reg, posf_next;
    logic        ok_e;
    logic [1:0]  k_reg, k_next;
    logic [61:0] sq;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] x_reg, x_next, res_reg, res_next, bit_reg, bit_next, trial;
    logic [31:0] n;
    logic        dbusy_reg, dbusy_next;
    logic [4:0]  ds_reg, ds_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] rem2;
    logic [16:0] nb_reg, nb_next, q_reg, q_next;
    logic [47:0] num;

    // result
    logic        found_reg, found_next;
    logic [15:0] gain_reg [3];
    logic [15:0] gain_next [3];
    logic [5:0]  chan_reg [3];
    logic [5:0]  chan_next [3];
    logic        out_v_reg, out_v_next;
    rsp_t        out_reg, out_next;
    logic        out_load;
    logic [31:0] lv32;

    vtrp_ram #(.WIDTH(COEF_BITS), .DEPTH(BDEPTH)) u_basis (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
    );

    vtrp_ram #(.WIDTH(6), .DEPTH(CDEPTH)) u_chan (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
    );

    assign limit = (32'(cfg.region_count) > CAP) ? 7'(CAP) : cfg.region_count;
    assign lv32  = 32'(q_item.load_value);
    assign tol_s = RAW_W'(cfg.sign_tolerance);

    // load writes, taken straight from the queue head
    assign b_we    = (state_reg == ST_IDLE) && q_valid && (q_item.req_type == REQ_LOAD_BASIS)
                     && (32'(q_item.region_index) < MAX_REGIONS) && (q_item.entry_index <= 4'd8);
    assign b_waddr = BAW'(32'(q_item.region_index) * 9 + 32'(q_item.entry_index));
    assign b_wdata = lv32[COEF_BITS-1:0];
    assign c_we    = (state_reg == ST_IDLE) && q_valid && (q_item.req_type == REQ_LOAD_CHAN)
                     && (32'(q_item.region_index) < MAX_REGIONS) && (q_item.entry_index <= 4'd2)
                     && !lv32[31] && (lv32 <= 32'd63) && (lv32 < MAX_CHANNELS);
    assign c_waddr = CAW'(32'(q_item.region_index) * 3 + 32'(q_item.entry_index));
    assign c_wdata = lv32[5:0];

    assign b_re    = (state_reg == ST_READ);
    assign b_raddr = BAW'(32'(r_reg) * 9 + 32'(i_reg) * 3 + 32'(j_reg));
    assign c_re    = (state_reg == ST_CHAN) && (k_reg != 2'd3);
    assign c_raddr = CAW'(32'(r_reg) * 3 + 32'(k_reg));

    assign pa = PROD_W'(pos_reg[rd1_i_reg]);
    assign pb = PROD_W'($signed(b_rdata));

    // triplet test and magnitudes
    always_comb
    begin
        ok_e = 1'b1;
        m_e  = '0;
        for (int t = 0; t < 3; t++)
        begin
            if (acc_reg[t] < -tol_s)
            begin
                ok_e = 1'b0;
            end
            mag_e[t] = acc_reg[t][RAW_W-1] ? RAW_W'(-acc_reg[t]) : RAW_W'(acc_reg[t]);
            if (mag_e[t] > m_e)
            begin
                m_e = mag_e[t];
            end
        end
    end

    assign sq    = 62'(mag_reg[k_reg][30:0]) * 62'(mag_reg[k_reg][30:0]);
    assign trial = res_reg + bit_reg;
    assign n     = res_reg[31:0];
    assign num   = {1'b0, mag_reg[k_reg][30:0], 16'b0} + 48'(n >> 1);
    assign rem2  = {rem_reg, nb_reg[16]};

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        r_next     = r_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pos_next   = pos_reg;
        rd1_v_next = (state_reg == ST_READ);
        acc_clear  = 1'b0;
        mag_next   = mag_reg;
        m_next     = m_reg;
        posf_next  = posf_reg;
        k_next     = k_reg;
        sum_next   = sum_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        dbusy_next = dbusy_reg;
        ds_next    = ds_reg;
        rem_next   = rem_reg;
        nb_next    = nb_reg;
        q_next     = q_reg;
        found_next = found_reg;
        gain_next  = gain_reg;
        chan_next  = chan_reg;
        out_load   = 1'b0;
        out_next   = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.req_type == REQ_PAN)
                    begin
                        pos_next[0] = q_item.pos_x;
                        pos_next[1] = q_item.pos_y;
                        pos_next[2] = q_item.pos_z;
                        r_next      = '0;
                        i_next      = '0;
                        j_next      = '0;
                        found_next  = 1'b0;
                        acc_clear   = 1'b1;
                        state_next  = (limit == '0) ? ST_EMIT : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // issue one basis word a cycle, row-major
                if (j_reg == 2'd2)
                begin
                    j_next = '0;
                    if (i_reg == 2'd2)
                    begin
                        i_next     = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!rd1_v_reg && !prod_v_reg)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!ok_e)
                begin
                    r_next = r_reg + 1'b1;
                    if ((r_reg + 1'b1) >= limit)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        acc_clear  = 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (m_e == '0)
                begin
                    // zero norm ends the search with nothing found
                    state_next = ST_EMIT;
                end
                else
                begin
                    found_next = 1'b1;
                    mag_next   = mag_e;
                    m_next     = m_e;
                    for (int t = 0; t < 3; t++)
                    begin
                        posf_next[t] = !acc_reg[t][RAW_W-1] && (acc_reg[t] != '0);
                    end
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (m_reg[RAW_W-1:31] != '0)
                begin
                    m_next = m_reg >> 1;
                    for (int t = 0; t < 3; t++)
                    begin
                        mag_next[t] = mag_reg[t] >> 1;
                    end
                end
                else if (m_reg[RAW_W-1:30] == '0)
                begin
                    m_next = m_reg << 1;
                    for (int t = 0; t < 3; t++)
                    begin
                        mag_next[t] = mag_reg[t] << 1;
                    end
                end
                else
                begin
                    k_next     = '0;
                    sum_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                sum_next = sum_reg + 64'(sq);
                if (k_reg == 2'd2)
                begin
                    x_next     = sum_reg + 64'(sq);
                    res_next   = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = ST_SQRT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 64'd1)
                begin
                    k_next     = '0;
                    dbusy_next = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!dbusy_reg)
                begin
                    if (posf_reg[k_reg])
                    begin
                        rem_next   = 32'(num[47:17]);
                        nb_next    = num[16:0];
                        q_next     = '0;
                        ds_next    = '0;
                        dbusy_next = 1'b1;
                    end
                    else
                    begin
                        gain_next[k_reg] = '0;
                        if (k_reg == 2'd2)
                        begin
                            k_next     = '0;
                            state_next = ST_CHAN;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                end
                else if (ds_reg == 5'd17)
                begin
                    // saturate a gain of one or more
                    gain_next[k_reg] = q_reg[16] ? 16'hFFFF : q_reg[15:0];
                    dbusy_next       = 1'b0;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = '0;
                        state_next = ST_CHAN;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    if (rem2 >= {1'b0, n})
                    begin
                        rem_next = 32'(rem2 - {1'b0, n});
                        q_next   = {q_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem2[31:0];
                        q_next   = {q_reg[15:0], 1'b0};
                    end
                    nb_next = nb_reg << 1;
                    ds_next = ds_reg + 1'b1;
                end
            end
            ST_CHAN:
            begin
                if (k_reg != 2'd0)
                begin
                    chan_next[k_reg - 1'b1] = c_rdata;
                end
                if (k_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_v_reg || rsp_ready)
                begin
                    out_load = 1'b1;
                    out_next = '0;
                    if (found_reg)
                    begin
                        out_next.found      = 1'b1;
                        out_next.hit_region = r_reg[5:0];
                        out_next.chan_a     = chan_reg[0];
                        out_next.chan_b     = chan_reg[1];
                        out_next.chan_c     = chan_reg[2];
                        out_next.gain_a     = gain_reg[0];
                        out_next.gain_b     = gain_reg[1];
                        out_next.gain_c     = gain_reg[2];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // accumulate the product pipeline
        for (int t = 0; t < 3; t++)
        begin
            if (acc_clear)
            begin
                acc_next[t] = '0;
            end
            else if (prod_v_reg && (prod_j_reg == 2'(t)))
            begin
                acc_next[t] = acc_reg[t] + RAW_W'(prod_reg);
            end
            else
            begin
                acc_next[t] = acc_reg[t];
            end
        end

        if (out_load)
        begin
            out_v_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd1_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            dbusy_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd1_v_reg  <= rd1_v_next;
            prod_v_reg <= rd1_v_reg;
            out_v_reg  <= out_v_next;
            dbusy_reg  <= dbusy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        pos_reg    <= pos_next;
        rd1_i_reg  <= i_reg;
        rd1_j_reg  <= j_reg;
        prod_j_reg <= rd1_j_reg;
        prod_reg   <= pa * pb;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        m_reg      <= m_next;
        posf_reg   <= posf_next;
        k_reg      <= k_next;
        sum_reg    <= sum_next;
        x_reg      <= x_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        ds_reg     <= ds_next;
        rem_reg    <= rem_next;
        nb_reg     <= nb_next;
        q_reg      <= q_next;
        found_reg  <= found_next;
        gain_reg   <= gain_next;
        chan_reg   <= chan_next;
        out_reg    <= out_next;
    end

endmodule

>>> src/vbap_triplet_region_panner_unit.sv
// Top level of the triplet region panner: configuration registers, front and back.
//
// Loads a table of loudspeaker triplets (inverse 3x3 basis plus three channel
// numbers each) and pans a source direction onto the first triplet whose raw
// gains are all at least minus the sign tolerance, giving power-normalised
// unsigned Q0.16 gains. A pan item searches the triplets in order: the nine
// basis words of a triplet come one a cycle from the single read port of the
// basis memory, through one multiplier into three accumulators, then the
// product pipeline drains and the gains are tested. A hit adds the
// normalisation: a scaling shift of one bit at a time (up to 30 bits), the
// sum of the three squares, 32 square-root steps, a division per positive
// gain and three channel reads. A short queue sits between acceptance and
// execution, and a result register holds a finished result while the next
// items are worked on. Configuration is accepted in every cycle and is to be
// written only while the block is idle. Stores are undefined after reset
// until loaded; there is no clearing pass.
module vbap_triplet_region_panner_unit import vtrp_pkg::*; #(
    parameter int MAX_REGIONS  = MAX_REGIONS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int COEF_BITS    = COEF_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_valid, q_pop;
    req_t q_item;

    // registers are always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_REGION_COUNT: cfg_reg.region_count   <= cfg_data[6:0];
                CFG_SIGN_TOL:     cfg_reg.sign_tolerance <= cfg_data;
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // accept and queue items
    vtrp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    // execute loads and pans in order
    vtrp_back #(
        .MAX_REGIONS(MAX_REGIONS), .MAX_CHANNELS(MAX_CHANNELS), .COEF_BITS(COEF_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

endmodule

>>> src/vtrp_checker.sv
// Port checker for the triplet region panner, bound to the top level.
module vtrp_checker import vtrp_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input req_t                  req,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input rsp_t                  rsp,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.hit_region == 6'd0 && rsp.chan_a == 6'd0
            && rsp.chan_b == 6'd0 && rsp.chan_c == 6'd0 && rsp.gain_a == 16'd0
            && rsp.gain_b == 16'd0 && rsp.gain_c == 16'd0)
        else $error("miss result carries data");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind vbap_triplet_region_panner_unit vtrp_checker u_vtrp_checker (.*);

>>> test/pan_scoreboard.sv
// Scoreboard of the triplet region panner: table copy, pan prediction and result check.
`timescale 1ns / 1ps
class pan_scoreboard;
    logic signed [23:0] coef_mem [0:575];
    logic [5:0]         chan_mem [0:191];
    logic [6:0]         span;
    logic [7:0]         tol;
    vtrp_pkg::rsp_t     due_q [$];
    int unsigned        faults;

    function new();
        span   = '0;
        tol    = '0;
        faults = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
        if (idx == vtrp_pkg::CFG_REGION_COUNT)
            span = data[6:0];
        else if (idx == vtrp_pkg::CFG_SIGN_TOL)
            tol = data;
    endfunction

    static function longint unsigned root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function vtrp_pkg::rsp_t pan(vtrp_pkg::req_t it);
        vtrp_pkg::rsp_t  r;
        longint          p [3];
        longint          raw [3];
        longint unsigned mag [3];
        longint unsigned top, acc, nrm, g;
        int              lim;
        bit              ok;
        r    = '0;
        p[0] = it.pos_x;
        p[1] = it.pos_y;
        p[2] = it.pos_z;
        lim  = (span > 64) ? 64 : span;
        for (int t = 0; t < lim; t++)
        begin
            ok = 1;
            for (int j = 0; j < 3; j++)
            begin
                raw[j] = 0;
                for (int i = 0; i < 3; i++)
                    raw[j] += p[i] * longint'(coef_mem[t*9 + i*3 + j]);
                if (raw[j] < -longint'(tol))
                    ok = 0;
            end
            if (!ok)
                continue;
            top = 0;
            for (int j = 0; j < 3; j++)
            begin
                mag[j] = (raw[j] < 0) ? longint'(-raw[j]) : raw[j];
                if (mag[j] > top)
                    top = mag[j];
            end
            if (top == 0)
                return r;
            while (top >= (64'd1 << 31))
            begin
                top >>= 1;
                for (int j = 0; j < 3; j++)
                    mag[j] >>= 1;
            end
            while (top < (64'd1 << 30))
            begin
                top <<= 1;
                for (int j = 0; j < 3; j++)
                    mag[j] <<= 1;
            end
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += mag[j] * mag[j];
            nrm          = root(acc);
            r.found      = 1'b1;
            r.hit_region = t[5:0];
            r.chan_a     = chan_mem[t*3];
            r.chan_b     = chan_mem[t*3 + 1];
            r.chan_c     = chan_mem[t*3 + 2];
            for (int j = 0; j < 3; j++)
            begin
                g = 0;
                if (raw[j] > 0)
                begin
                    g = ((mag[j] << 16) + (nrm >> 1)) / nrm;
                    if (g > 65535)
                        g = 65535;
                end
                case (j)
                    0: r.gain_a = g[15:0];
                    1: r.gain_b = g[15:0];
                    default: r.gain_c = g[15:0];
                endcase
            end
            return r;
        end
        return r;
    endfunction

    function void note_item(vtrp_pkg::req_t it);
        case (it.req_type)
            vtrp_pkg::REQ_LOAD_BASIS:
                if (it.entry_index <= 8)
                    coef_mem[it.region_index*9 + it.entry_index] = it.load_value;
            vtrp_pkg::REQ_LOAD_CHAN:
                if (it.entry_index <= 2 && it.load_value >= 0 && it.load_value <= 63)
                    chan_mem[it.region_index*3 + it.entry_index] = it.load_value[5:0];
            vtrp_pkg::REQ_PAN:
                due_q = {due_q, pan(it)};
            default: ;
        endcase
    endfunction

    function void check_result(vtrp_pkg::rsp_t got);
        vtrp_pkg::rsp_t exp;
        if (due_q.size() == 0)
        begin
            faults++;
            if (faults <= 10)
                $display("unexpected result %p", got);
            return;
        end
        exp = due_q.pop_front();
        if (got.found !== exp.found || got.hit_region !== exp.hit_region ||
            got.chan_a !== exp.chan_a || got.chan_b !== exp.chan_b ||
            got.chan_c !== exp.chan_c || got.gain_a !== exp.gain_a ||
            got.gain_b !== exp.gain_b || got.gain_c !== exp.gain_c)
        begin
            faults++;
            if (faults <= 10)
                $display("mismatch: expected %p actual %p", exp, got);
        end
    endfunction
endclass

>>> test/testbench.sv
// Top of the triplet region panner testbench: clock, reset, drivers, monitors and stimulus.
`timescale 1ns / 1ps
module testbench;
    import vtrp_pkg::*;

    localparam int REQ_W = $bits(req_t);

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    req_t          req = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    rsp_t          rsp;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [7:0]    cfg_data = '0;

    pan_scoreboard sb = new();
    int            quiet_cycles = 0;
    bit            hold_request = 0;
    int            burst_left = 0;

    vbap_triplet_region_panner_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sample every handshake at the edge, before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_item(req);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: a pan tries at most 64 triplets plus normalisation, and the long receiver hold ends.
    always @(posedge clk)
    begin
        if (quiet_cycles > 20000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: its own stall pattern, changed at random, plus one long
    // hold when asked so that the queue fills and the input stalls.
    initial
    begin
        int mode;
        int hold;
        int tick;
        mode = 0;
        hold = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                hold = 3000;
            end
            if (tick % 150 == 0)
                mode = $urandom_range(0, 3);
            tick++;
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= ($urandom_range(0, 1) == 0);
                    2: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ((tick % 8) < 5);
                endcase
        end
    end

    // Offer one item and hold it until accepted; bursts end in a random gap.
    task automatic send_item(req_t it);
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        if (burst_left == 0)
        begin
            int gap;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 20);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Drain every expected result, then let trailing loads finish in the back end.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic req_t load_item(logic [1:0] kind, int region, int slot,
                                       logic signed [23:0] value);
        req_t it;
        it              = '0;
        it.req_type     = kind;
        it.region_index = region[5:0];
        it.entry_index  = slot[3:0];
        it.load_value   = value;
        return it;
    endfunction

    function automatic req_t pan_item(int x, int y, int z);
        req_t it;
        it          = '0;
        it.req_type = REQ_PAN;
        it.pos_x    = x[15:0];
        it.pos_y    = y[15:0];
        it.pos_z    = z[15:0];
        return it;
    endfunction

    function automatic req_t random_pan();
        req_t it;
        it          = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
        it.req_type = REQ_PAN;
        case ($urandom_range(0, 9))
            0: begin it.pos_x = '0; it.pos_y = '0; it.pos_z = '0; end
            1: it.pos_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: ;
        endcase
        return it;
    endfunction

    // Noise: loads that the block drops, and the unused request type.
    function automatic req_t noise_item();
        req_t it;
        it = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
        case ($urandom_range(0, 3))
            0:
            begin
                it.req_type    = REQ_LOAD_BASIS;
                it.entry_index = 4'($urandom_range(9, 15));
            end
            1:
            begin
                it.req_type    = REQ_LOAD_CHAN;
                it.entry_index = 4'($urandom_range(3, 15));
            end
            2:
            begin
                it.req_type    = REQ_LOAD_CHAN;
                it.entry_index = 4'($urandom_range(0, 2));
                it.load_value  = $urandom_range(0, 1) ? 24'(-$urandom_range(1, 8388608))
                                                      : 24'($urandom_range(64, 8388607));
            end
            default: it.req_type = REQ_UNUSED;
        endcase
        return it;
    endfunction

    initial
    begin
        req_t it;
        int   rc_set [6];
        int   tol_set [6];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, nothing loaded: search of zero triplets and dropped items.
        write_reg(CFG_REGION_COUNT, 8'd0);
        write_reg(CFG_SIGN_TOL, 8'd0);
        send_item(pan_item(1000, 2000, 3000));
        repeat (6) send_item(noise_item());
        settle();

        // Fill the whole table. Triplet 0 is the identity, 1 its negation,
        // 2 a diagonal of one LSB to probe the sign tolerance.
        for (int t = 0; t < 64; t++)
        begin
            for (int w = 0; w < 9; w++)
            begin
                logic signed [23:0] c;
                c = 24'($urandom);
                if (t < 3)
                    c = (w % 4 != 0) ? 24'sd0 : (t == 0) ? 24'sd65536 :
                        (t == 1) ? -24'sd65536 : 24'sd1;
                send_item(load_item(REQ_LOAD_BASIS, t, w, c));
            end
            for (int s = 0; s < 3; s++)
                send_item(load_item(REQ_LOAD_CHAN, t, s,
                                    (t == 0 && s == 2) ? 24'sd63
                                                       : 24'($urandom_range(0, 63))));
        end
        settle();

        // Directed pans over the three special triplets.
        write_reg(CFG_REGION_COUNT, 8'd3);
        send_item(pan_item(32767, 0, 0));          // saturated gain
        send_item(pan_item(0, 0, 0));              // zero norm
        send_item(pan_item(16384, 16384, 16384));  // equal gains
        send_item(pan_item(-32768, -32768, -32768));
        send_item(pan_item(1000, -100, 500));      // rejected at zero tolerance
        send_item(pan_item(-32768, 32767, 0));     // no triplet holds it
        settle();
        write_reg(CFG_SIGN_TOL, 8'd255);
        send_item(pan_item(1000, -100, 500));      // slightly negative, now accepted
        send_item(pan_item(1000, -255, 500));
        send_item(pan_item(1000, -256, 500));
        settle();

        // Random phases over several settings, extremes included. Phase two
        // offers only pans under a long receiver hold so that the block fills.
        rc_set  = '{1, 64, 127, 100, 0, -1};
        tol_set = '{0, 255, 0, 255, 0, -1};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_REGION_COUNT,
                      8'(rc_set[ph] < 0 ? $urandom_range(1, 127) : rc_set[ph]));
            write_reg(CFG_SIGN_TOL,
                      8'(tol_set[ph] < 0 ? $urandom_range(0, 255) : tol_set[ph]));
            for (int n = 0; n < 12; n++)
            begin
                if (ph == 2 && n == 0)
                    hold_request = 1;
                if (ph == 2)
                    send_item(random_pan());
                else
                    case ($urandom_range(0, 19))
                        0, 1: send_item(load_item(REQ_LOAD_BASIS, $urandom_range(3, 63),
                                                  $urandom_range(0, 8), 24'($urandom)));
                        2:    send_item(load_item(REQ_LOAD_CHAN, $urandom_range(0, 63),
                                                  $urandom_range(0, 2),
                                                  24'($urandom_range(0, 63))));
                        3, 4: send_item(noise_item());
                        default: send_item(random_pan());
                    endcase
            end
            settle();
        end

        repeat (800) @(posedge clk);
        if (sb.faults == 0 && sb.due_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
src/vtrp_pkg.sv
src/vtrp_ram.sv
src/vtrp_front.sv
src/vtrp_back.sv
src/vbap_triplet_region_panner_unit.sv
src/vtrp_checker.sv
test/pan_scoreboard.sv
test/testbench.sv
